// ===== rtl/assert_macros.svh =====
// Assertion macros used by the list engine top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ALC_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("alc assertion failed");
`define ALC_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("alc assertion failed");
`else
`define ALC_ASSERT(lbl, clk, rst_n, prop)
`define ALC_ASSERT_ALWAYS(lbl, clk, prop)
`endif
`endif

// ===== rtl/alc_pkg.sv =====
// Types and constants of the list engine.
`timescale 1ns / 1ps
package alc_pkg;

  localparam int unsigned ALC_DEPTH  = 64;
  localparam int unsigned ALC_DATA_W = 32;
  localparam int unsigned ALC_IDX_W  = 6;
  localparam int unsigned ALC_CNT_W  = 7;

  typedef enum logic [1:0] {
    OP_PUSH  = 2'd0,
    OP_POP   = 2'd1,
    OP_ERASE = 2'd2,
    OP_FIND  = 2'd3
  } alc_op_t;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_FULL   = 2'd1,
    ST_EMPTY  = 2'd2,
    ST_BADIDX = 2'd3
  } alc_status_t;

  typedef struct packed {
    alc_op_t                        operation;
    logic signed [ALC_DATA_W-1:0]   value;
    logic        [ALC_IDX_W-1:0]    index;
  } alc_in_t;

  typedef struct packed {
    alc_status_t                    status;
    logic                           found;
    logic        [ALC_IDX_W-1:0]    found_index;
    logic        [ALC_CNT_W-1:0]    count;
  } alc_out_t;

  // Per-cycle commands broadcast to every cell.
  typedef struct packed {
    logic push;
    logic erase;
    logic find;
    logic scan;
  } alc_ctl_t;

endpackage

// ===== rtl/array_list_engine.sv =====
// Top level of the list engine: count, sequencer, output register and the cell row.
//
//   channel | direction | payload  | transfer when
//   in_     | input     | alc_in_t  | in_valid && !in_stall
//   out_    | output    | alc_out_t | out_valid && !out_stall
//
// Push, pop and erase results are registered at the transfer edge.
// Find on an empty list registers its result at the transfer edge; otherwise it scans:
// match flags move one cell per cycle toward cell 0, where they are checked.
// Reset (rst_n low, synchronous) empties the list and drops any pending result.
// in_stall is high during a find scan and while a held result is stalled.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module array_list_engine import alc_pkg::*; #(
  parameter int unsigned DEPTH = ALC_DEPTH
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  alc_in_t  in_data,
  output logic     out_valid,
  input  logic     out_stall,
  output alc_out_t out_data
);

  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam int unsigned POS_W = $clog2(DEPTH);

  typedef enum logic {
    S_IDLE,
    S_SCAN
  } state_t;

  state_t                        state_r;
  logic        [CNT_W-1:0]       count_r;
  logic        [CNT_W-1:0]       count_nxt;
  logic        [POS_W-1:0]       pos_r;
  logic                          out_valid_r;
  alc_out_t                      out_data_r;

  logic                          in_acc;
  logic                          out_free;
  logic                          full;
  logic                          empty;
  logic                          idx_ok;
  logic                          head;
  logic                          last;
  logic                          res_load;
  logic        [CNT_W-1:0]       pos_inc;
  alc_status_t                   status_imm;
  alc_out_t                      res_imm;
  alc_out_t                      res_find;
  alc_ctl_t                      ctl;

  logic signed [ALC_DATA_W-1:0]  cell_data  [DEPTH];
  logic                          cell_match [DEPTH];

  assign out_free = !out_valid_r || !out_stall;
  assign in_stall = (state_r != S_IDLE) || !out_free;
  assign in_acc   = in_valid && !in_stall;

  assign full   = count_r == CNT_W'(DEPTH);
  assign empty  = count_r == '0;
  assign idx_ok = int'(in_data.index) < int'(count_r);

  assign head    = cell_match[0];
  assign pos_inc = CNT_W'(pos_r) + CNT_W'(1);
  assign last    = pos_inc >= count_r;

  // a new result enters the output register this cycle
  assign res_load = ((state_r == S_IDLE) && in_acc &&
                     !((in_data.operation == OP_FIND) && !empty)) ||
                    ((state_r == S_SCAN) && (head || last) && out_free);

  always_comb begin
    count_nxt  = count_r;
    status_imm = ST_OK;
    unique case (in_data.operation)
      OP_PUSH: begin
        if (full) status_imm = ST_FULL;
        else      count_nxt  = count_r + CNT_W'(1);
      end
      OP_POP: begin
        if (empty) status_imm = ST_EMPTY;
        else       count_nxt  = count_r - CNT_W'(1);
      end
      OP_ERASE: begin
        if (!idx_ok) status_imm = ST_BADIDX;
        else         count_nxt  = count_r - CNT_W'(1);
      end
      OP_FIND: begin
        status_imm = ST_OK;
      end
      default: begin
        status_imm = ST_OK;
      end
    endcase
    if (!in_acc) count_nxt = count_r;
  end

  always_comb begin
    res_imm.status      = status_imm;
    res_imm.found       = 1'b0;
    res_imm.found_index = '0;
    res_imm.count       = ALC_CNT_W'(count_nxt);

    res_find.status      = ST_OK;
    res_find.found       = head;
    res_find.found_index = head ? ALC_IDX_W'(pos_r) : '0;
    res_find.count       = ALC_CNT_W'(count_r);
  end

  always_comb begin
    ctl.push  = in_acc && (in_data.operation == OP_PUSH) && !full;
    ctl.erase = in_acc && (in_data.operation == OP_ERASE) && idx_ok;
    ctl.find  = in_acc && (in_data.operation == OP_FIND);
    ctl.scan  = (state_r == S_SCAN) && !head && !last;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r <= count_nxt;
      if (out_valid_r && !out_stall && !res_load) out_valid_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            if ((in_data.operation == OP_FIND) && !empty) begin
              state_r <= S_SCAN;
              pos_r   <= '0;
            end else begin
              out_valid_r <= 1'b1;
              out_data_r  <= res_imm;
            end
          end
        end
        S_SCAN: begin
          if (head || last) begin
            if (out_free) begin
              out_valid_r <= 1'b1;
              out_data_r  <= res_find;
              state_r     <= S_IDLE;
            end
          end else begin
            pos_r <= pos_r + POS_W'(1);
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic signed [ALC_DATA_W-1:0] up_data;
    logic                         up_match;
    if (i == DEPTH - 1) begin : g_end
      assign up_data  = cell_data[i];
      assign up_match = 1'b0;
    end else begin : g_mid
      assign up_data  = cell_data[i+1];
      assign up_match = cell_match[i+1];
    end
    alc_cell #(
      .POS   (i),
      .CNT_W (CNT_W)
    ) u_cell (
      .clk      (clk),
      .ctl      (ctl),
      .count    (count_r),
      .index    (in_data.index),
      .key      (in_data.value),
      .up_data  (up_data),
      .up_match (up_match),
      .data_o   (cell_data[i]),
      .match_o  (cell_match[i])
    );
  end

  `ALC_ASSERT(a_count_bound, clk, rst_n, count_r <= CNT_W'(DEPTH))
  `ALC_ASSERT(a_scan_stalls, clk, rst_n, (state_r == S_SCAN) |-> in_stall)
  `ALC_ASSERT(a_quick_result, clk, rst_n, (in_acc && (in_data.operation != OP_FIND)) |=> out_valid_r)
  `ALC_ASSERT(a_count_hold, clk, rst_n, !in_acc |=> $stable(count_r))

endmodule

// ===== rtl/alc_cell.sv =====
// One list cell: holds an entry and its match flag, takes data from the cell above.
`timescale 1ns / 1ps
module alc_cell import alc_pkg::*; #(
  parameter int unsigned POS   = 0,
  parameter int unsigned CNT_W = 7
) (
  input  logic                          clk,
  input  alc_ctl_t                      ctl,
  input  logic        [CNT_W-1:0]       count,
  input  logic        [ALC_IDX_W-1:0]   index,
  input  logic signed [ALC_DATA_W-1:0]  key,
  input  logic signed [ALC_DATA_W-1:0]  up_data,
  input  logic                          up_match,
  output logic signed [ALC_DATA_W-1:0]  data_o,
  output logic                          match_o
);

  localparam logic [CNT_W-1:0] POS_C = CNT_W'(POS);

  logic signed [ALC_DATA_W-1:0] data_r;
  logic                         match_r;
  logic                         in_list;
  logic                         at_tail;
  logic                         shift_sel;

  assign in_list   = POS_C < count;
  assign at_tail   = POS_C == count;
  assign shift_sel = int'(POS) >= int'(index);

  always_ff @(posedge clk) begin
    if (ctl.push && at_tail) begin
      data_r <= key;
    end else if (ctl.erase && shift_sel) begin
      data_r <= up_data;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.find) begin
      match_r <= in_list && (data_r == key);
    end else if (ctl.scan) begin
      match_r <= up_match;
    end
  end

  assign data_o  = data_r;
  assign match_o = match_r;

endmodule
